[hdl/skhct_pkg.sv]
// Shared types, codes and defaults for the sorted key hit counter table.
package skhct_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] request_size;
        logic [9:0]  read_index;
    } req_t;

    typedef struct packed {
        logic [31:0] entry_key;
        logic [31:0] entry_hits;
        logic [9:0]  entry_position;
        logic        found;
        logic        inserted;
        logic        table_full;
        logic [10:0] stored_entries;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_PLACE,
        ST_SHIFT,
        ST_INSERT,
        ST_RESULT
    } state_t;

endpackage

[hdl/skhct_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
module skhct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/skhct_seq.sv]
// Sequencer: binary search probe, shift-down insert and entry readout over the table RAMs.
module skhct_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  skhct_pkg::req_t                req,
    output logic                           res_valid,
    input  logic                           res_ready,
    output skhct_pkg::rsp_t                res,
    output logic [$clog2(TABLE_DEPTH)-1:0] mem_raddr,
    output logic [$clog2(TABLE_DEPTH)-1:0] mem_waddr,
    output logic                           key_we,
    output logic                           hit_we,
    output logic [KEY_WIDTH-1:0]           key_wdata,
    output logic [31:0]                    hit_wdata,
    input  logic [KEY_WIDTH-1:0]           key_rdata,
    input  logic [31:0]                    hit_rdata
);

    import skhct_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > 10) ? CW : 10;

    state_t              state_reg, state_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [AW-1:0]       mid_reg, mid_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       shift_reg, shift_next;
    logic [CW-1:0]       count_reg, count_next;
    rsp_t                res_reg, res_next;

    logic [CW-1:0]       lo_probe, hi_probe;
    logic [31:0]         hits_inc;

    // Midpoint of the half-open interval [lo, hi): floor((lo + hi - 1) / 2).
    function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
        logic [CW:0] s;
        s = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
        return AW'(s >> 1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        pos_reg   <= pos_next;
        shift_reg <= shift_next;
        res_reg   <= res_next;
    end

    // Shared probe: one compare and one interval update per cycle.
    always_comb
    begin
        lo_probe = lo_reg;
        hi_probe = hi_reg;
        if (key_rdata < key_reg)
        begin
            hi_probe = CW'(mid_reg);
        end
        else
        begin
            lo_probe = CW'(mid_reg) + CW'(1);
        end
        hits_inc = (hit_rdata == HITS_MAX) ? hit_rdata : hit_rdata + 32'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        pos_next   = pos_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        mem_raddr  = mid_reg;
        mem_waddr  = mid_reg;
        key_we     = 1'b0;
        hit_we     = 1'b0;
        key_wdata  = key_rdata;
        hit_wdata  = hit_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    key_next = KEY_WIDTH'(req.request_size);
                    if (req.func == FUNC_READ)
                    begin
                        pos_next  = CW'(req.read_index);
                        mem_raddr = AW'(req.read_index);
                        if (CMPW'(req.read_index) < CMPW'(count_reg))
                        begin
                            state_next = ST_READ;
                        end
                        else
                        begin
                            res_next                = '0;
                            res_next.entry_position = req.read_index;
                            res_next.stored_entries = 11'(count_reg);
                            state_next              = ST_RESULT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        mid_next   = mid_of('0, count_reg);
                        mem_raddr  = mid_of('0, count_reg);
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_READ:
            begin
                res_next.entry_key      = 32'(key_rdata);
                res_next.entry_hits     = hit_rdata;
                res_next.entry_position = 10'(pos_reg);
                res_next.found          = 1'b1;
                res_next.inserted       = 1'b0;
                res_next.table_full     = 1'b0;
                res_next.stored_entries = 11'(count_reg);
                state_next              = ST_RESULT;
            end

            ST_SEARCH:
            begin
                if (key_rdata == key_reg)
                begin
                    // Hit: bump the count in place, saturating.
                    hit_we                  = 1'b1;
                    mem_waddr               = mid_reg;
                    hit_wdata               = hits_inc;
                    res_next.entry_key      = 32'(key_rdata);
                    res_next.entry_hits     = hits_inc;
                    res_next.entry_position = 10'(mid_reg);
                    res_next.found          = 1'b1;
                    res_next.inserted       = 1'b0;
                    res_next.table_full     = 1'b0;
                    res_next.stored_entries = 11'(count_reg);
                    state_next              = ST_RESULT;
                end
                else
                begin
                    lo_next = lo_probe;
                    hi_next = hi_probe;
                    if (lo_probe < hi_probe)
                    begin
                        mid_next  = mid_of(lo_probe, hi_probe);
                        mem_raddr = mid_of(lo_probe, hi_probe);
                    end
                    else
                    begin
                        pos_next   = lo_probe;
                        state_next = ST_PLACE;
                    end
                end
            end

            ST_PLACE:
            begin
                if (count_reg >= CW'(TABLE_DEPTH))
                begin
                    res_next                = '0;
                    res_next.entry_key      = 32'(key_reg);
                    res_next.table_full     = 1'b1;
                    res_next.stored_entries = 11'(count_reg);
                    state_next              = ST_RESULT;
                end
                else if (pos_reg == count_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    mem_raddr  = AW'(count_reg - CW'(1));
                    shift_next = AW'(count_reg - CW'(1));
                    state_next = ST_SHIFT;
                end
            end

            ST_SHIFT:
            begin
                // Move entry j down to j + 1 while fetching j - 1.
                key_we    = 1'b1;
                hit_we    = 1'b1;
                mem_waddr = shift_reg + AW'(1);
                key_wdata = key_rdata;
                hit_wdata = hit_rdata;
                if (CW'(shift_reg) == pos_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    mem_raddr  = shift_reg - AW'(1);
                    shift_next = shift_reg - AW'(1);
                end
            end

            ST_INSERT:
            begin
                key_we                  = 1'b1;
                hit_we                  = 1'b1;
                mem_waddr               = AW'(pos_reg);
                key_wdata               = key_reg;
                hit_wdata               = 32'd1;
                count_next              = count_reg + CW'(1);
                res_next.entry_key      = 32'(key_reg);
                res_next.entry_hits     = 32'd1;
                res_next.entry_position = 10'(pos_reg);
                res_next.found          = 1'b0;
                res_next.inserted       = 1'b1;
                res_next.table_full     = 1'b0;
                res_next.stored_entries = 11'(count_reg + CW'(1));
                state_next              = ST_RESULT;
            end

            ST_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("entry count changed by other than one");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        (key_we || hit_we) |->
            (state_reg == ST_SEARCH || state_reg == ST_SHIFT || state_reg == ST_INSERT))
        else $error("table write outside search, shift or insert");

    a_search_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("search interval empty or beyond valid entries");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (CW'(shift_reg) >= pos_reg && CW'(shift_reg) < count_reg))
        else $error("shift index outside insertion range");

endmodule

[hdl/sorted_key_hit_counter_table.sv]
// Top level: sorted key hit counter table with request and response channels.
//
// Requests enter on req (valid/ready). func FUNC_COUNT looks up request_size in a
// table of distinct keys held in descending order; a match bumps its hit count
// (saturating), a miss inserts the key with a count of one at its sorted place,
// and a miss on a full table is dropped with table_full set. func FUNC_READ
// returns the entry at read_index. Each request gives exactly one response on rsp.
// A count request is accepted when idle, then runs binary search probes, one per
// cycle (at most ceil(log2(entries + 1)), 11 for a full 1024-entry table). On a
// miss it goes on through placement, one shift step per entry moved down (entries
// minus position) and the insert; the result then goes to the output register.
// The probe loop and the shift loop share the single read and write port of each
// table RAM. A miss on a full table skips the shift and the insert. A read request
// passes through the read state, or goes straight to the result when read_index is
// not below the entry count. Only one request is in flight: req_ready is high only
// while the sequencer is idle, which includes while a response still waits in the
// output register. When the receiver stalls, hold the response; a finished second
// request then waits in the sequencer until the register frees.
// Reset empties the table by clearing the entry count; RAM contents are left as
// they are, since only positions below the count are ever used.
module sorted_key_hit_counter_table #(
    parameter int TABLE_DEPTH = skhct_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = skhct_pkg::DEF_KEY_WIDTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  skhct_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output skhct_pkg::rsp_t rsp
);

    import skhct_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [AW-1:0]        mem_raddr;
    logic [AW-1:0]        mem_waddr;
    logic                 key_we;
    logic                 hit_we;
    logic [KEY_WIDTH-1:0] key_wdata;
    logic [KEY_WIDTH-1:0] key_rdata;
    logic [31:0]          hit_wdata;
    logic [31:0]          hit_rdata;

    logic                 res_valid;
    logic                 res_ready;
    rsp_t                 res;

    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // Key and hit count live in two RAMs addressed in lockstep.
    skhct_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (mem_waddr),
        .wdata (key_wdata),
        .raddr (mem_raddr),
        .rdata (key_rdata)
    );

    skhct_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (mem_waddr),
        .wdata (hit_wdata),
        .raddr (mem_raddr),
        .rdata (hit_rdata)
    );

    skhct_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_raddr (mem_raddr),
        .mem_waddr (mem_waddr),
        .key_we    (key_we),
        .hit_we    (hit_we),
        .key_wdata (key_wdata),
        .hit_wdata (hit_wdata),
        .key_rdata (key_rdata),
        .hit_rdata (hit_rdata)
    );

    // Output register: load when empty or being drained this cycle.
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[tb/sv/tb.sv]
// Testbench for the sorted key hit counter table: directed table and random traffic.
`timescale 1ns / 100ps

module tb;
    import skhct_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int POOL_SIZE   = 16;

    // One row of the directed table: the request, and where the answer is plain
    // from the table contents, the response typed in by hand.
    typedef struct packed {
        req_t item;
        logic typed;
        rsp_t want;
    } step_t;

    localparam int N_DIRECTED = 22;

    // Table contents after the typed rows: FFFFFFFF, 80, 10, 0 (descending).
    localparam step_t DIRECTED [N_DIRECTED] = '{
        // empty table: reads at both ends of the index range miss
        '{'{FUNC_READ, 32'hFFFF_FFFF, 10'd0}, 1'b1,
          '{32'h0, 32'd0, 10'd0, 1'b0, 1'b0, 1'b0, 11'd0}},
        '{'{FUNC_READ, 32'h0, 10'd1023}, 1'b1,
          '{32'h0, 32'd0, 10'd1023, 1'b0, 1'b0, 1'b0, 11'd0}},
        // first insert, then a hit on it
        '{'{FUNC_COUNT, 32'h10, 10'd1023}, 1'b1,
          '{32'h10, 32'd1, 10'd0, 1'b0, 1'b1, 1'b0, 11'd1}},
        '{'{FUNC_COUNT, 32'h10, 10'd0}, 1'b1,
          '{32'h10, 32'd2, 10'd0, 1'b1, 1'b0, 1'b0, 11'd1}},
        // largest key goes to the head, zero to the tail, 80 in between
        '{'{FUNC_COUNT, 32'hFFFF_FFFF, 10'd0}, 1'b1,
          '{32'hFFFF_FFFF, 32'd1, 10'd0, 1'b0, 1'b1, 1'b0, 11'd2}},
        '{'{FUNC_COUNT, 32'h0, 10'd1023}, 1'b1,
          '{32'h0, 32'd1, 10'd2, 1'b0, 1'b1, 1'b0, 11'd3}},
        '{'{FUNC_COUNT, 32'h80, 10'd0}, 1'b1,
          '{32'h80, 32'd1, 10'd1, 1'b0, 1'b1, 1'b0, 11'd4}},
        // hits at both ends
        '{'{FUNC_COUNT, 32'hFFFF_FFFF, 10'd0}, 1'b1,
          '{32'hFFFF_FFFF, 32'd2, 10'd0, 1'b1, 1'b0, 1'b0, 11'd4}},
        '{'{FUNC_COUNT, 32'h0, 10'd1023}, 1'b1,
          '{32'h0, 32'd2, 10'd3, 1'b1, 1'b0, 1'b0, 11'd4}},
        // reads: last valid entry, first invalid one, head
        '{'{FUNC_READ, 32'hFFFF_FFFF, 10'd3}, 1'b1,
          '{32'h0, 32'd2, 10'd3, 1'b1, 1'b0, 1'b0, 11'd4}},
        '{'{FUNC_READ, 32'h0, 10'd4}, 1'b1,
          '{32'h0, 32'd0, 10'd4, 1'b0, 1'b0, 1'b0, 11'd4}},
        '{'{FUNC_READ, 32'h0, 10'd0}, 1'b1,
          '{32'hFFFF_FFFF, 32'd2, 10'd0, 1'b1, 1'b0, 1'b0, 11'd4}},
        // the rest go through the predictor
        '{'{FUNC_COUNT, 32'h5555_5555, 10'h2AA}, 1'b0, '0},
        '{'{FUNC_COUNT, 32'hAAAA_AAAA, 10'h155}, 1'b0, '0},
        '{'{FUNC_COUNT, 32'hFFFF_FFFE, 10'd0}, 1'b0, '0},
        '{'{FUNC_COUNT, 32'h1, 10'd0}, 1'b0, '0},
        '{'{FUNC_READ, 32'h0, 10'd1023}, 1'b0, '0},
        '{'{FUNC_COUNT, 32'h80, 10'd0}, 1'b0, '0},
        '{'{FUNC_READ, 32'h0, 10'd2}, 1'b0, '0},
        '{'{FUNC_COUNT, 32'h10, 10'd0}, 1'b0, '0},
        '{'{FUNC_COUNT, 32'h7FFF_FFFF, 10'd0}, 1'b0, '0},
        '{'{FUNC_READ, 32'h0, 10'd8}, 1'b0, '0}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow copy of the table, kept in step with accepted requests.
    logic [31:0] shadow_keys [TABLE_DEPTH];
    logic [31:0] shadow_hits [TABLE_DEPTH];
    int          shadow_count = 0;

    rsp_t        due_responses [$];
    int          err_count = 0;
    bit          bursty = 1'b1;
    int          stall_left = 0;
    logic [31:0] key_pool [POOL_SIZE];

    sorted_key_hit_counter_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the response it must give.
    function automatic rsp_t count_or_read(input req_t item);
        rsp_t        r;
        int          lo;
        int          hi;
        int          mid;
        int          i;
        logic [31:0] key;
        r = '0;
        if (item.func == FUNC_READ)
        begin
            r.entry_position = item.read_index;
            r.stored_entries = shadow_count[10:0];
            if (item.read_index < shadow_count)
            begin
                r.entry_key  = shadow_keys[item.read_index];
                r.entry_hits = shadow_hits[item.read_index];
                r.found      = 1'b1;
            end
            return r;
        end
        key = item.request_size;
        lo  = 0;
        hi  = shadow_count - 1;
        // Binary search over a descending table.
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (shadow_keys[mid] < key)
                hi = mid - 1;
            else if (shadow_keys[mid] > key)
                lo = mid + 1;
            else
            begin
                // Saturate the count instead of wrapping.
                if (shadow_hits[mid] != HITS_MAX)
                    shadow_hits[mid] = shadow_hits[mid] + 32'd1;
                r.entry_key      = key;
                r.entry_hits     = shadow_hits[mid];
                r.entry_position = mid[9:0];
                r.found          = 1'b1;
                r.stored_entries = shadow_count[10:0];
                return r;
            end
        end
        // Miss on a full table: drop the size, leave the table alone.
        if (shadow_count >= TABLE_DEPTH)
        begin
            r.entry_key      = key;
            r.table_full     = 1'b1;
            r.stored_entries = shadow_count[10:0];
            return r;
        end
        // Miss: move the smaller keys down by one and place the new size.
        for (i = shadow_count; i > lo; i--)
        begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_hits[i] = shadow_hits[i - 1];
        end
        shadow_keys[lo]  = key;
        shadow_hits[lo]  = 32'd1;
        shadow_count     = shadow_count + 1;
        r.entry_key      = key;
        r.entry_hits     = 32'd1;
        r.entry_position = lo[9:0];
        r.inserted       = 1'b1;
        r.stored_entries = shadow_count[10:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // Offer one request, hold it until accepted, then queue its response.
    task automatic issue(input req_t item, input logic typed, input rsp_t want);
        int   gap;
        rsp_t predicted;
        // Drop valid for a short burst now and then.
        if (bursty && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        // Always advance the shadow table; a typed row overrides the response.
        predicted = count_or_read(item);
        due_responses.push_back(typed ? want : predicted);
    endtask

    // Receiver: stall in random bursts while bursty is set.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= (stall_left == 1);
        end
        else if (bursty && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 5);
            rsp_ready  <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare every accepted response against the oldest one due.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_responses.size() == 0)
            begin
                $error("response with nothing due: key %0h", rsp.entry_key);
                err_count++;
            end
            else
            begin
                want = due_responses.pop_front();
                check_field("entry_key", want.entry_key, rsp.entry_key);
                check_field("entry_hits", want.entry_hits, rsp.entry_hits);
                check_field("entry_position", 32'(want.entry_position),
                            32'(rsp.entry_position));
                check_field("found", 32'(want.found), 32'(rsp.found));
                check_field("inserted", 32'(want.inserted), 32'(rsp.inserted));
                check_field("table_full", 32'(want.table_full), 32'(rsp.table_full));
                check_field("stored_entries", 32'(want.stored_entries),
                            32'(rsp.stored_entries));
            end
        end
    end

    initial
    begin
        req_t        item;
        int          n;
        int          pick;
        for (n = 0; n < TABLE_DEPTH; n++)
        begin
            shadow_keys[n] = '0;
            shadow_hits[n] = '0;
        end
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        for (n = 0; n < N_DIRECTED; n++)
            issue(DIRECTED[n].item, DIRECTED[n].typed, DIRECTED[n].want);

        // Random mix: hits on a pool of recurring sizes, fresh sizes, near misses
        // next to pool sizes, and reads mostly inside the valid range.
        for (n = 0; n < 420; n++)
        begin
            if (n % 50 == 49)
                bursty <= ($urandom_range(0, 3) != 0);
            item.func         = FUNC_COUNT;
            item.request_size = $urandom;
            item.read_index   = 10'($urandom_range(0, 1023));
            pick = $urandom_range(0, 99);
            if (pick < 35)
                item.request_size = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick < 45)
                item.request_size = key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                    + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            else if (pick >= 70)
            begin
                item.func = FUNC_READ;
                if (shadow_count > 0 && $urandom_range(0, 9) < 7)
                    item.read_index = 10'($urandom_range(0, shadow_count - 1));
            end
            issue(item, 1'b0, '0);
        end

        // Last part, no idling: fresh sizes, pool hits and reads back to back.
        bursty <= 1'b0;
        for (n = 0; n < 60; n++)
        begin
            item.func         = FUNC_COUNT;
            item.request_size = $urandom;
            item.read_index   = 10'($urandom_range(0, 1023));
            pick = $urandom_range(0, 2);
            if (pick == 1)
                item.request_size = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (pick == 2)
                item.func = FUNC_READ;
            issue(item, 1'b0, '0);
        end
        req_valid <= 1'b0;

        // Drain, then keep running a while longer for anything stray.
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Timeout: several times the slowest legal run.
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
